FILE: src/blink_sequence_detector_unit_defines.svh
`ifndef BLINK_SEQUENCE_DETECTOR_UNIT_DEFINES_SVH
`define BLINK_SEQUENCE_DETECTOR_UNIT_DEFINES_SVH

// Shared assertion macros. Each expects clk and arst_n in the enclosing module.

// Same-cycle implication.
`define BSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

	// Field widths.
	localparam int TIME_W   = 32;
	localparam int COORD_W  = 16;
	localparam int TICK_W   = 32;
	localparam int REP_W    = 8;
	localparam int CNT_W    = 16;
	localparam int HALF_W   = REP_W - 1;
	localparam int PROD_W   = TICK_W + REP_W;
	localparam int CMP_W    = ((TIME_W > TICK_W) ? TIME_W : TICK_W) + REP_W;

	// Stream and configuration port widths.
	localparam int PAY_W    = TIME_W + 2 * COORD_W;
	localparam int DATA_W   = ((PAY_W + 7) / 8) * 8;
	localparam int USER_W   = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REPETITIONS  = 3'd0,
		REG_MIN_ON_SMP   = 3'd1,
		REG_MIN_PAUSE_SMP = 3'd2,
		REG_MIN_ON_TICKS = 3'd3,
		REG_MIN_PAUSE_TICKS = 3'd4,
		REG_MAX_PAUSE_TICKS = 3'd5
	} reg_idx_t;

	// Register reset values.
	localparam logic [REP_W-1:0]  RST_REPETITIONS     = REP_W'(2);
	localparam logic [CNT_W-1:0]  RST_MIN_ON_SMP      = CNT_W'(1);
	localparam logic [CNT_W-1:0]  RST_MIN_PAUSE_SMP   = CNT_W'(2);
	localparam logic [TICK_W-1:0] RST_MIN_ON_TICKS    = TICK_W'(150000);
	localparam logic [TICK_W-1:0] RST_MIN_PAUSE_TICKS = TICK_W'(150000);
	localparam logic [TICK_W-1:0] RST_MAX_PAUSE_TICKS = TICK_W'(1000000);

	// Threshold partial products at reset: (h + 1) * on and h * pause with h = 1.
	localparam logic [PROD_W-1:0] RST_THR_ON    = PROD_W'(300000);
	localparam logic [PROD_W-1:0] RST_THR_PAUSE = PROD_W'(150000);

	// Saturation limits.
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [REP_W-1:0] REP_MAX = {REP_W{1'b1}};

	// Configuration as seen by the matcher.
	typedef struct packed {
		logic [REP_W-1:0]  repetitions;
		logic [CNT_W-1:0]  min_on_samples;
		logic [CNT_W-1:0]  min_pause_samples;
		logic [TICK_W-1:0] min_on_ticks;
		logic [TICK_W-1:0] min_pause_ticks;
		logic [TICK_W-1:0] max_pause_ticks;
		logic [PROD_W-1:0] thr_on;
		logic [PROD_W-1:0] thr_pause;
	} cfg_t;

	// One input sample.
	typedef struct packed {
		logic               first_of_history;
		logic [TIME_W-1:0]  sample_time;
		logic               triggered;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
	} item_t;

	// Matcher status toward the top level.
	typedef struct packed {
		logic emit;
		logic idle;
	} match_stat_t;

endpackage

FILE: src/blink_sequence_detector_unit.sv
// Blink sequence detector. Samples enter on the slave stream, one per beat, and
// a new beat is taken on every clock unless the result register is stalled or a
// configuration write holds the input off. A match result is offered on the
// master stream from the result register once the completing sample has left
// the input register and passed the matcher, the single stage that sets the rate;
// it judges each sample and updates its state as the sample leaves. After a
// configuration write the input is held off while the total-time threshold
// products are registered; configuration writes complete in the beat offered.
`timescale 1ns / 1ps
`include "blink_sequence_detector_unit_defines.svh"

module blink_sequence_detector_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// Sample stream.
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata: sample_time, pos_x, pos_y, zero padding.
	input  logic [bsd_pkg::DATA_W-1:0]       s_axis_tdata,
	// tuser: first_of_history, triggered.
	input  logic [bsd_pkg::USER_W-1:0]       s_axis_tuser,
	// Event stream.
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// tdata: event_time, event_x, event_y, zero padding.
	output logic [bsd_pkg::DATA_W-1:0]       m_axis_tdata,
	// Configuration write channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bsd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	bsd_pkg::cfg_t         cfg;
	bsd_pkg::item_t        item_s1;
	bsd_pkg::match_stat_t  stat;
	logic                  valid_s1;
	logic                  advance;
	logic                  cfg_wr;
	logic                  cfg_hold_q;
	logic                  out_valid_q;
	logic [bsd_pkg::PAY_W-1:0] out_pay_q;

	// Handshakes.
	assign cfg_ready     = 1'b1;
	assign cfg_wr        = cfg_valid && cfg_ready;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !cfg_hold_q && (!valid_s1 || advance);

	bsd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Hold the input in the cycle after a write so the threshold settles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_hold_q <= 1'b0;
		end else begin
			cfg_hold_q <= cfg_wr;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.first_of_history <= s_axis_tuser[0];
			item_s1.triggered        <= s_axis_tuser[1];
			item_s1.sample_time      <= s_axis_tdata[bsd_pkg::TIME_W-1:0];
			item_s1.pos_x <= s_axis_tdata[bsd_pkg::TIME_W +: bsd_pkg::COORD_W];
			item_s1.pos_y <= s_axis_tdata[bsd_pkg::TIME_W + bsd_pkg::COORD_W +: bsd_pkg::COORD_W];
		end
	end

	bsd_match u_match (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.stat   (stat)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && stat.emit) begin
			out_pay_q <= {item_s1.pos_y, item_s1.pos_x, item_s1.sample_time};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = bsd_pkg::DATA_W'(out_pay_q);

	`BSD_ASSERT_NXT(a_cfg_blocks_input, cfg_wr, !s_axis_tready,
		"sample accepted while threshold was settling")
	`BSD_ASSERT_NXT(a_stalled_item_kept, valid_s1 && !advance, valid_s1,
		"pending sample lost while the result was stalled")
	`BSD_ASSERT_NXT(a_result_from_match, !m_axis_tvalid && !(advance && stat.emit),
		!m_axis_tvalid, "result appeared without a match")

endmodule

FILE: src/bsd_cfg.sv
`timescale 1ns / 1ps

module bsd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [bsd_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [bsd_pkg::CFG_DATA_W-1:0]   wr_data,
	output bsd_pkg::cfg_t                    cfg
);

	logic [bsd_pkg::REP_W-1:0]  repetitions_q;
	logic [bsd_pkg::CNT_W-1:0]  min_on_samples_q;
	logic [bsd_pkg::CNT_W-1:0]  min_pause_samples_q;
	logic [bsd_pkg::TICK_W-1:0] min_on_ticks_q;
	logic [bsd_pkg::TICK_W-1:0] min_pause_ticks_q;
	logic [bsd_pkg::TICK_W-1:0] max_pause_ticks_q;
	logic [bsd_pkg::PROD_W-1:0] thr_on_q;
	logic [bsd_pkg::PROD_W-1:0] thr_pause_q;
	logic [bsd_pkg::HALF_W-1:0] half_rep;

	// Half the repetition count, rounded down.
	assign half_rep = repetitions_q[bsd_pkg::REP_W-1:1];

	// Register file writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repetitions_q       <= bsd_pkg::RST_REPETITIONS;
			min_on_samples_q    <= bsd_pkg::RST_MIN_ON_SMP;
			min_pause_samples_q <= bsd_pkg::RST_MIN_PAUSE_SMP;
			min_on_ticks_q      <= bsd_pkg::RST_MIN_ON_TICKS;
			min_pause_ticks_q   <= bsd_pkg::RST_MIN_PAUSE_TICKS;
			max_pause_ticks_q   <= bsd_pkg::RST_MAX_PAUSE_TICKS;
		end else if (wr_en) begin
			case (bsd_pkg::reg_idx_t'(wr_index))
				bsd_pkg::REG_REPETITIONS: begin
					repetitions_q <= wr_data[bsd_pkg::REP_W-1:0];
				end
				bsd_pkg::REG_MIN_ON_SMP: begin
					min_on_samples_q <= wr_data[bsd_pkg::CNT_W-1:0];
				end
				bsd_pkg::REG_MIN_PAUSE_SMP: begin
					min_pause_samples_q <= wr_data[bsd_pkg::CNT_W-1:0];
				end
				bsd_pkg::REG_MIN_ON_TICKS: begin
					min_on_ticks_q <= wr_data[bsd_pkg::TICK_W-1:0];
				end
				bsd_pkg::REG_MIN_PAUSE_TICKS: begin
					min_pause_ticks_q <= wr_data[bsd_pkg::TICK_W-1:0];
				end
				bsd_pkg::REG_MAX_PAUSE_TICKS: begin
					max_pause_ticks_q <= wr_data[bsd_pkg::TICK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Total-time threshold partial products, registered in the cycle after the registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_on_q    <= bsd_pkg::RST_THR_ON;
			thr_pause_q <= bsd_pkg::RST_THR_PAUSE;
		end else begin
			thr_on_q    <= bsd_pkg::PROD_W'(({1'b0, half_rep} + bsd_pkg::REP_W'(1))
				* min_on_ticks_q);
			thr_pause_q <= bsd_pkg::PROD_W'(half_rep * min_pause_ticks_q);
		end
	end

	assign cfg.repetitions       = repetitions_q;
	assign cfg.min_on_samples    = min_on_samples_q;
	assign cfg.min_pause_samples = min_pause_samples_q;
	assign cfg.min_on_ticks      = min_on_ticks_q;
	assign cfg.min_pause_ticks   = min_pause_ticks_q;
	assign cfg.max_pause_ticks   = max_pause_ticks_q;
	assign cfg.thr_on            = thr_on_q;
	assign cfg.thr_pause         = thr_pause_q;

endmodule

FILE: src/bsd_match.sv
`timescale 1ns / 1ps
`include "blink_sequence_detector_unit_defines.svh"

module bsd_match (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  bsd_pkg::item_t        item,
	input  bsd_pkg::cfg_t         cfg,
	output bsd_pkg::match_stat_t  stat
);

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ON    = 2'd1,
		PH_PAUSE = 2'd2
	} phase_t;

	phase_t                     phase_q, phase_d, phase_eff;
	logic [bsd_pkg::REP_W-1:0]  done_q, done_d, done_eff, done_inc;
	logic [bsd_pkg::CNT_W-1:0]  smp_q, smp_d, smp_eff, smp_inc;
	logic [bsd_pkg::TIME_W-1:0] streak_start_q, streak_start_d;
	logic [bsd_pkg::TIME_W-1:0] match_start_q, match_start_d;
	logic [bsd_pkg::TIME_W-1:0] span, match_span;
	logic [bsd_pkg::CMP_W-1:0]  span_x, match_span_x, threshold;
	logic                       on_fail, pause_fail, emit;

	// Start of history wipes the matcher before the sample is handled.
	always_comb begin
		phase_eff = item.first_of_history ? PH_IDLE : phase_q;
		done_eff  = item.first_of_history ? '0 : done_q;
		smp_eff   = item.first_of_history ? '0 : smp_q;
	end

	// Saturating counters and wrapped time spans.
	assign smp_inc      = (smp_eff == bsd_pkg::CNT_MAX) ? smp_eff : smp_eff + 1'b1;
	assign done_inc     = (done_eff == bsd_pkg::REP_MAX) ? done_eff : done_eff + 1'b1;
	assign span         = item.sample_time - streak_start_q;
	assign match_span   = item.sample_time - match_start_q;
	assign span_x       = bsd_pkg::CMP_W'(span);
	assign match_span_x = bsd_pkg::CMP_W'(match_span);
	assign threshold    = bsd_pkg::CMP_W'(cfg.thr_on) + bsd_pkg::CMP_W'(cfg.thr_pause);

	// Streak checks.
	assign on_fail = (smp_eff < cfg.min_on_samples)
		|| (span_x < bsd_pkg::CMP_W'(cfg.min_on_ticks));
	assign pause_fail = (smp_eff < cfg.min_pause_samples)
		|| (span_x < bsd_pkg::CMP_W'(cfg.min_pause_ticks))
		|| (span_x > bsd_pkg::CMP_W'(cfg.max_pause_ticks));

	// Next state for the sample at hand.
	always_comb begin
		phase_d        = phase_eff;
		done_d         = done_eff;
		smp_d          = smp_eff;
		streak_start_d = streak_start_q;
		match_start_d  = match_start_q;
		emit           = 1'b0;
		case (phase_eff)
			PH_ON: begin
				if (item.triggered) begin
					smp_d = smp_inc;
				end else if (on_fail) begin
					phase_d = PH_IDLE;
					done_d  = '0;
					smp_d   = '0;
				end else begin
					phase_d        = PH_PAUSE;
					streak_start_d = item.sample_time;
					smp_d          = bsd_pkg::CNT_W'(1);
					done_d         = done_inc;
					if ((done_inc >= cfg.repetitions) && (match_span_x > threshold)) begin
						emit    = 1'b1;
						phase_d = PH_IDLE;
						done_d  = '0;
						smp_d   = '0;
					end
				end
			end
			PH_PAUSE: begin
				if (!item.triggered) begin
					smp_d = smp_inc;
				end else if (pause_fail) begin
					phase_d        = PH_ON;
					streak_start_d = item.sample_time;
					match_start_d  = item.sample_time;
					smp_d          = bsd_pkg::CNT_W'(1);
					done_d         = '0;
				end else begin
					phase_d        = PH_ON;
					streak_start_d = item.sample_time;
					smp_d          = bsd_pkg::CNT_W'(1);
				end
			end
			default: begin
				if (item.triggered) begin
					phase_d        = PH_ON;
					streak_start_d = item.sample_time;
					match_start_d  = item.sample_time;
					smp_d          = bsd_pkg::CNT_W'(1);
					done_d         = '0;
				end else begin
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	// Matcher state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			done_q         <= '0;
			smp_q          <= '0;
			streak_start_q <= '0;
			match_start_q  <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			done_q         <= done_d;
			smp_q          <= smp_d;
			streak_start_q <= streak_start_d;
			match_start_q  <= match_start_d;
		end
	end

	assign stat.emit = emit;
	assign stat.idle = (phase_q == PH_IDLE);

	`BSD_ASSERT_NXT(a_emit_goes_idle, step && emit, phase_q == PH_IDLE && done_q == '0,
		"matcher did not return to idle after a match")
	`BSD_ASSERT_IMP(a_streak_counted, phase_q == PH_ON || phase_q == PH_PAUSE, smp_q != '0,
		"active streak has no samples")
	`BSD_ASSERT_IMP(a_done_needs_match, done_q != '0, phase_q == PH_ON || phase_q == PH_PAUSE,
		"passed streaks counted outside a match")

endmodule
